// ----- design/bft_pkg.sv -----
// shared types, constants and bfloat16 arithmetic for the tanh pipeline
package bft_pkg;

    localparam int NSTG = 10;

    localparam logic [15:0] LN2_BITS     = 16'h3f31;
    localparam logic [15:0] INV_LN2_BITS = 16'h3fb9;
    localparam logic [15:0] QNAN_POS     = 16'h7fc0;
    localparam logic [15:0] QNAN_NEG     = 16'hffc0;
    localparam logic [15:0] ONE_POS      = 16'h3f80;
    localparam logic [15:0] ONE_NEG      = 16'hbf80;
    localparam logic [15:0] NEG_LIMIT    = 16'hc05d;
    localparam logic [15:0] POS_LIMIT    = 16'h405d;
    localparam logic [15:0] SIGN_MASK    = 16'h8000;

    localparam logic [15:0] TAB_V [0:10] = '{16'hbf80, 16'hbf7e, 16'hbf78, 16'hbf62,
        16'hbf1a, 16'h0000, 16'h3f1a, 16'h3f62, 16'h3f78, 16'h3f7e, 16'h3f80};
    localparam logic [15:0] TAB_D1 [0:10] = '{16'h3b80, 16'h3c7e, 16'h3d78, 16'h3e63,
        16'h3f24, 16'h3f80, 16'h3f24, 16'h3e63, 16'h3d78, 16'h3c7e, 16'h3b80};
    localparam logic [15:0] TAB_D2 [0:10] = '{16'h3b7f, 16'h3c7c, 16'h3d71, 16'h3e48,
        16'h3ec5, 16'h0000, 16'hbec5, 16'hbe48, 16'hbd71, 16'hbc7c, 16'hbb7f};
    localparam logic [15:0] TAB_D3 [0:10] = '{16'h3b29, 16'h3c25, 16'h3d16, 16'h3dca,
        16'h3c8c, 16'hbeab, 16'h3c8c, 16'h3dca, 16'h3d16, 16'h3c25, 16'h3b29};

    typedef struct packed {
        logic               s;
        logic signed [11:0] e;
        logic        [7:0]  m;
    } unp_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] val;
    } spec_t;

    function automatic unp_t bf_unpack(input logic [15:0] b);
        unp_t u;
        u.s = b[15];
        if (b[14:7] == 8'd0)
        begin
            u.m = {1'b0, b[6:0]};
            u.e = -12'sd133;
        end
        else
        begin
            u.m = {1'b1, b[6:0]};
            u.e = $signed({4'b0, b[14:7]}) - 12'sd134;
        end
        return u;
    endfunction

    // round s * m * 2^e to nearest even, subnormals kept
    function automatic logic [15:0] bf_pack(input logic s, input logic [19:0] m,
                                            input logic signed [11:0] e);
        logic signed [11:0] p;
        logic signed [11:0] sh;
        logic signed [11:0] lim;
        logic signed [11:0] nsh;
        logic signed [11:0] shm1;
        logic signed [11:0] ee;
        logic signed [11:0] field;
        logic [19:0] r;
        logic rb;
        logic st;
        p = 12'sd0;
        for (int i = 0; i < 20; i++)
        begin
            if (m[i])
                p = 12'(i);
        end
        sh = p - 12'sd7;
        lim = -12'sd133 - e;
        if (lim > sh)
            sh = lim;
        nsh = -sh;
        shm1 = sh - 12'sd1;
        rb = 1'b0;
        st = 1'b0;
        if (sh <= 12'sd0)
            r = m << nsh[2:0];
        else if (sh >= 12'sd21)
            r = 20'd0;
        else
        begin
            r = m >> sh[4:0];
            rb = m[shm1[4:0]];
            st = |(m & ((20'd1 << shm1[4:0]) - 20'd1));
        end
        if (rb && (st || r[0]))
            r = r + 20'd1;
        ee = sh + e;
        if (r[8])
        begin
            r = 20'd128;
            ee = ee + 12'sd1;
        end
        field = ee + 12'sd134;
        if (m == 20'd0)
            return {s, 15'd0};
        if (r[7])
        begin
            if (field >= 12'sd255)
                return {s, 15'h7f80};
            return {s, field[7:0], r[6:0]};
        end
        return {s, 8'd0, r[6:0]};
    endfunction

    function automatic logic [15:0] bf_mul(input logic [15:0] a, input logic [15:0] b);
        unp_t ua;
        unp_t ub;
        logic [15:0] prod;
        ua = bf_unpack(a);
        ub = bf_unpack(b);
        prod = ua.m * ub.m;
        return bf_pack(ua.s ^ ub.s, {4'b0, prod}, ua.e + ub.e);
    endfunction

    function automatic logic [15:0] bf_add(input logic [15:0] a, input logic [15:0] b);
        unp_t ua;
        unp_t ub;
        unp_t hi;
        unp_t lo;
        logic signed [11:0] d;
        logic signed [11:0] k;
        logic [19:0] x;
        logic [19:0] y;
        logic stk;
        ua = bf_unpack(a);
        ub = bf_unpack(b);
        if (ua.m == 8'd0 && ub.m == 8'd0)
            return (ua.s && ub.s) ? SIGN_MASK : 16'd0;
        if (ua.m == 8'd0)
            return b;
        if (ub.m == 8'd0)
            return a;
        if (ub.e > ua.e)
        begin
            hi = ub;
            lo = ua;
        end
        else
        begin
            hi = ua;
            lo = ub;
        end
        d = hi.e - lo.e;
        k = d - 12'sd11;
        x = {1'b0, hi.m, 11'd0};
        if (d <= 12'sd11)
            y = {1'b0, lo.m, 11'd0} >> d[3:0];
        else if (k >= 12'sd8)
            y = 20'd1;
        else
        begin
            // far operand collapses into a sticky bit below the round position
            stk = |(lo.m & ((8'd1 << k[2:0]) - 8'd1));
            y = {12'd0, lo.m >> k[2:0]} | {19'd0, stk};
        end
        if (hi.s == lo.s)
            return bf_pack(hi.s, x + y, hi.e - 12'sd11);
        if (x > y)
            return bf_pack(hi.s, x - y, hi.e - 12'sd11);
        if (y > x)
            return bf_pack(lo.s, y - x, hi.e - 12'sd11);
        return 16'd0;
    endfunction

endpackage

// ----- design/bft_mul_stage.sv -----
// registered bfloat16 multiply stage
module bft_mul_stage
    import bft_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] y
);

    logic [15:0] y_reg;
    logic [15:0] y_next;

    assign y_next = bf_mul(a, b);

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ----- design/bft_add_stage.sv -----
// registered bfloat16 add stage
module bft_add_stage
    import bft_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] y
);

    logic [15:0] y_reg;
    logic [15:0] y_next;

    assign y_next = bf_add(a, b);

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ----- design/bft_reduce.sv -----
// rounds the scaled operand to an integer n and forms the table index
module bft_reduce
    import bft_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] p,
    output logic [15:0] nb,
    output logic [3:0]  idx
);

    logic [15:0] nb_reg;
    logic [15:0] nb_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;

    unp_t               up;
    logic signed [11:0] k;
    logic signed [11:0] km1;
    logic [9:0]         mag;
    logic               sat;

    always_comb
    begin
        up = bf_unpack(p);
        k = -up.e;
        km1 = k - 12'sd1;
        sat = 1'b0;
        mag = 10'd0;
        nb_next = p;
        if (up.e >= 12'sd0)
            sat = 1'b1;
        else
        begin
            // ties away from zero on the magnitude
            if (k < 12'sd9)
                mag = ({2'b0, up.m} + (10'd1 << km1[3:0])) >> k[3:0];
            nb_next = bf_pack(up.s, {10'd0, mag}, 12'sd0);
        end
        if (up.m == 8'd0)
        begin
            sat = 1'b0;
            mag = 10'd0;
        end
        if (sat || mag >= 10'd5)
            idx_next = up.s ? 4'd0 : 4'd10;
        else if (up.s)
            idx_next = 4'd5 - mag[3:0];
        else
            idx_next = 4'd5 + mag[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nb_reg <= nb_next;
            idx_reg <= idx_next;
        end
    end

    assign nb = nb_reg;
    assign idx = idx_reg;

endmodule

// ----- design/bf16_tanh_taylor.sv -----
// bfloat16 tanh: range reduction by ln2 and a cubic taylor polynomial, fully pipelined
// stages in order: scale by 1/ln2, reduce, n*ln2, dx, then three multiply/add pairs (one bf16 operation per stage)
// throughput: one word per cycle; a stalled output freezes the whole pipeline in place
// rate is set by the ten single-operation stages, each holding one word
// reset: rst_n clears all stage valid bits asynchronously; the data path is not reset
module bf16_tanh_taylor
    import bft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operand_valid,
    output logic        operand_stall,
    input  logic [15:0] operand_bits,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] result_bits
);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            adv;
    logic            accept;

    spec_t       sp_next;
    spec_t       sp_reg [0:NSTG-1];
    logic [15:0] a_reg [0:2];
    logic [3:0]  idx_reg [3:9];
    logic [15:0] dx_reg [5:8];

    logic [15:0] p1;
    logic [15:0] nb2;
    logic [3:0]  idx2;
    logic [15:0] q3;
    logic [15:0] dx4;
    logic [15:0] m5;
    logic [15:0] s6;
    logic [15:0] m7;
    logic [15:0] s8;
    logic [15:0] m9;
    logic [15:0] s10;

    assign adv = !vld_reg[NSTG-1] || !result_stall;
    assign operand_stall = !adv;
    assign accept = operand_valid && adv;
    assign vld_next = {vld_reg[NSTG-2:0], operand_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // operands that bypass the polynomial
    always_comb
    begin
        sp_next.hit = 1'b1;
        if (operand_bits[14:7] == 8'hff)
        begin
            if (operand_bits[6:0] != 7'd0)
                sp_next.val = operand_bits[15] ? QNAN_NEG : QNAN_POS;
            else
                sp_next.val = operand_bits[15] ? ONE_NEG : ONE_POS;
        end
        else if (operand_bits > NEG_LIMIT)
            sp_next.val = ONE_NEG;
        else if (operand_bits > POS_LIMIT && !operand_bits[15])
            sp_next.val = ONE_POS;
        else
        begin
            sp_next.hit = 1'b0;
            sp_next.val = ONE_POS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_reg[0] <= sp_next;
            for (int i = 1; i < NSTG; i++)
                sp_reg[i] <= sp_reg[i-1];
            a_reg[0] <= operand_bits;
            a_reg[1] <= a_reg[0];
            a_reg[2] <= a_reg[1];
            idx_reg[3] <= idx2;
            for (int i = 4; i <= 9; i++)
                idx_reg[i] <= idx_reg[i-1];
            dx_reg[5] <= dx4;
            dx_reg[6] <= dx_reg[5];
            dx_reg[7] <= dx_reg[6];
            dx_reg[8] <= dx_reg[7];
        end
    end

    bft_mul_stage u_scale (.clk(clk), .en(adv), .a(operand_bits), .b(INV_LN2_BITS), .y(p1));

    bft_reduce u_reduce (.clk(clk), .en(adv), .p(p1), .nb(nb2), .idx(idx2));

    bft_mul_stage u_nln2 (.clk(clk), .en(adv), .a(nb2), .b(LN2_BITS), .y(q3));

    bft_add_stage u_dx (.clk(clk), .en(adv), .a(a_reg[2]), .b(q3 ^ SIGN_MASK), .y(dx4));

    bft_mul_stage u_h0 (.clk(clk), .en(adv), .a(dx4), .b(TAB_D3[idx_reg[4]]), .y(m5));

    bft_add_stage u_h1 (.clk(clk), .en(adv), .a(TAB_D2[idx_reg[5]]), .b(m5), .y(s6));

    bft_mul_stage u_h2 (.clk(clk), .en(adv), .a(dx_reg[6]), .b(s6), .y(m7));

    bft_add_stage u_h3 (.clk(clk), .en(adv), .a(TAB_D1[idx_reg[7]]), .b(m7), .y(s8));

    bft_mul_stage u_h4 (.clk(clk), .en(adv), .a(dx_reg[8]), .b(s8), .y(m9));

    bft_add_stage u_h5 (.clk(clk), .en(adv), .a(TAB_V[idx_reg[9]]), .b(m9), .y(s10));

    assign result_valid = vld_reg[NSTG-1];
    assign result_bits = sp_reg[NSTG-1].hit ? sp_reg[NSTG-1].val : s10;

`ifndef SYNTHESIS
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[NSTG-1:1] == $past(vld_reg[NSTG-2:0]))
        else $error("valid bits did not advance with the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> vld_reg[0])
        else $error("accepted word not captured in first stage");
`endif

endmodule

// ----- test/tb_bf16_tanh_taylor.sv -----
// testbench for the bfloat16 tanh pipeline: predicted results checked in order
module tb_bf16_tanh_taylor;
    import bft_pkg::*;

    localparam logic [15:0] TANH_V [0:10] = '{16'hbf80, 16'hbf7e, 16'hbf78, 16'hbf62,
        16'hbf1a, 16'h0000, 16'h3f1a, 16'h3f62, 16'h3f78, 16'h3f7e, 16'h3f80};
    localparam logic [15:0] TANH_D1 [0:10] = '{16'h3b80, 16'h3c7e, 16'h3d78, 16'h3e63,
        16'h3f24, 16'h3f80, 16'h3f24, 16'h3e63, 16'h3d78, 16'h3c7e, 16'h3b80};
    localparam logic [15:0] TANH_D2 [0:10] = '{16'h3b7f, 16'h3c7c, 16'h3d71, 16'h3e48,
        16'h3ec5, 16'h0000, 16'hbec5, 16'hbe48, 16'hbd71, 16'hbc7c, 16'hbb7f};
    localparam logic [15:0] TANH_D3 [0:10] = '{16'h3b29, 16'h3c25, 16'h3d16, 16'h3dca,
        16'h3c8c, 16'hbeab, 16'h3c8c, 16'h3dca, 16'h3d16, 16'h3c25, 16'h3b29};
    localparam int N_RANDOM = 1850;
    localparam int CALM_TAIL = 200;

    logic        clk;
    logic        rst_n;
    logic        operand_valid;
    logic        operand_stall;
    logic [15:0] operand_bits;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] result_bits;

    logic [15:0] pending_operands[$];
    logic [15:0] expected_tanh[$];
    int          n_errors;
    int          n_results;
    int          n_sent;
    int          total_items;
    bit          stimulus_ready;
    int          send_gap;
    int          recv_gap;

    bf16_tanh_taylor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand_bits  (operand_bits),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_bits   (result_bits)
    );

    // bf16 value as sign, 64-bit magnitude and exponent
    function automatic void split_bf(input logic [15:0] b, output bit s,
                                     output int e, output longint unsigned m);
        s = b[15];
        if (b[14:7] == 8'd0)
        begin
            m = b[6:0];
            e = -133;
        end
        else
        begin
            m = {1'b1, b[6:0]};
            e = int'(b[14:7]) - 134;
        end
    endfunction

    function automatic logic [15:0] round_bf(input bit s, input longint unsigned m,
                                             input int e);
        int p;
        int sh;
        int ee;
        longint unsigned r;
        longint unsigned t;
        bit rb;
        bit st;
        if (m == 0)
            return {s, 15'd0};
        p = 0;
        t = m;
        while ((t >>= 1) != 0)
            p++;
        sh = p - 7;
        if (-133 - e > sh)
            sh = -133 - e;
        rb = 0;
        st = 0;
        if (sh <= 0)
            r = m << (-sh);
        else if (sh > 64)
        begin
            r = 0;
            st = 1;
        end
        else if (sh == 64)
        begin
            r = 0;
            rb = m[63];
            st = (m << 1) != 0;
        end
        else
        begin
            r = m >> sh;
            rb = (m >> (sh - 1)) & 1;
            st = (m & ((64'd1 << (sh - 1)) - 1)) != 0;
        end
        if (rb && (st || r[0]))
            r++;
        ee = sh + e;
        if (r == 256)
        begin
            r = 128;
            ee++;
        end
        if (r >= 128)
        begin
            if (ee + 134 >= 255)
                return {s, 15'h7f80};
            return {s, 8'(ee + 134), r[6:0]};
        end
        return {s, 8'd0, r[6:0]};
    endfunction

    function automatic logic [15:0] mul_bf(input logic [15:0] a, input logic [15:0] b);
        bit sa, sb;
        int ea, eb;
        longint unsigned ma, mb;
        split_bf(a, sa, ea, ma);
        split_bf(b, sb, eb, mb);
        return round_bf(sa ^ sb, ma * mb, ea + eb);
    endfunction

    function automatic logic [15:0] add_bf(input logic [15:0] a, input logic [15:0] b);
        bit sa, sb, ts;
        int ea, eb, te, d, k;
        longint unsigned ma, mb, tm, x, y;
        split_bf(a, sa, ea, ma);
        split_bf(b, sb, eb, mb);
        if (ma == 0 && mb == 0)
            return (sa && sb) ? 16'h8000 : 16'h0000;
        if (ma == 0)
            return b;
        if (mb == 0)
            return a;
        if (eb > ea)
        begin
            ts = sa; sa = sb; sb = ts;
            te = ea; ea = eb; eb = te;
            tm = ma; ma = mb; mb = tm;
        end
        d = ea - eb;
        x = ma << 32;
        if (d <= 32)
            y = mb << (32 - d);
        else
        begin
            k = d - 32;
            if (k >= 8)
                y = 1;
            else
                y = (mb >> k) | longint'((mb & ((64'd1 << k) - 1)) != 0);
        end
        if (sa == sb)
            return round_bf(sa, x + y, ea - 32);
        if (x > y)
            return round_bf(sa, x - y, ea - 32);
        if (y > x)
            return round_bf(sb, y - x, ea - 32);
        return 16'h0000;
    endfunction

    function automatic logic [15:0] predict_tanh(input logic [15:0] a);
        logic [15:0] p, nb, dx, acc;
        bit ps;
        int pe, ni, idx, kk;
        longint unsigned pm, mag;
        if (a[14:7] == 8'hff)
        begin
            if (a[6:0] != 0)
                return a[15] ? QNAN_NEG : QNAN_POS;
            return a[15] ? ONE_NEG : ONE_POS;
        end
        if (a > NEG_LIMIT)
            return ONE_NEG;
        if (a > POS_LIMIT && a < SIGN_MASK)
            return ONE_POS;
        p = mul_bf(a, INV_LN2_BITS);
        split_bf(p, ps, pe, pm);
        if (pe >= 0)
        begin
            nb = p;
            mag = 32767;
        end
        else
        begin
            kk = -pe;
            mag = (kk >= 9) ? 0 : ((pm + (64'd1 << (kk - 1))) >> kk);
            nb = round_bf(ps, mag, 0);
        end
        if (pm == 0)
            mag = 0;
        ni = ps ? -int'(mag) : int'(mag);
        idx = ni + 5;
        if (idx < 0)
            idx = 0;
        if (idx > 10)
            idx = 10;
        dx = add_bf(a, mul_bf(nb, LN2_BITS) ^ SIGN_MASK);
        acc = mul_bf(dx, TANH_D3[idx]);
        acc = add_bf(TANH_D2[idx], acc);
        acc = mul_bf(dx, acc);
        acc = add_bf(TANH_D1[idx], acc);
        acc = mul_bf(dx, acc);
        return add_bf(TANH_V[idx], acc);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        logic [15:0] w;
        int sel;
        stimulus_ready = 0;
        // directed: zeros, extremes, specials, thresholds, tiny values
        pending_operands = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h007f, 16'h0080,
            16'h7f7f, 16'hff7f, 16'h7f80, 16'hff80, 16'h7fc0, 16'hffc0, 16'h7f81, 16'hffff,
            16'h405d, 16'h405e, 16'hc05d, 16'hc05e, 16'h3f31, 16'hbf31, 16'h3f80,
            16'hbf80, 16'h3e00, 16'h4000, 16'hc000};
        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                // mostly the polynomial range
                w = {1'($urandom), 8'($urandom_range(100, 128)), 7'($urandom)};
            else if (sel < 8)
                w = {1'($urandom), 8'($urandom_range(120, 128)), 7'($urandom)};
            else
                w = 16'($urandom);
            pending_operands.push_back(w);
        end
        total_items = pending_operands.size();
        stimulus_ready = 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_valid <= 1'b0;
            operand_bits <= 16'd0;
            send_gap <= 0;
            n_sent <= 0;
        end
        else if (!(operand_valid && operand_stall))
        begin
            if (operand_valid)
            begin
                expected_tanh.push_back(predict_tanh(operand_bits));
            end
            if (send_gap > 0)
            begin
                operand_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (stimulus_ready && pending_operands.size() > 0)
            begin
                operand_valid <= 1'b1;
                operand_bits <= pending_operands.pop_front();
                n_sent <= n_sent + 1;
                if (n_sent < total_items - CALM_TAIL && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 13);
            end
            else
                operand_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_gap <= 0;
            n_results <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                n_results <= n_results + 1;
                if (expected_tanh.size() == 0)
                begin
                    $error("result_bits: unexpected word, actual %h", result_bits);
                    n_errors++;
                end
                else
                begin
                    logic [15:0] want;
                    want = expected_tanh.pop_front();
                    if (want !== result_bits)
                    begin
                        $error("result_bits: expected %h, actual %h", want, result_bits);
                        n_errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                result_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end
            else if (n_sent < total_items - CALM_TAIL && $urandom_range(0, 11) == 0)
            begin
                result_stall <= 1'b1;
                recv_gap <= $urandom_range(0, 12);
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        n_errors = 0;
        wait (stimulus_ready);
        wait (rst_n);
        while (pending_operands.size() > 0 || operand_valid || expected_tanh.size() > 0)
            @(posedge clk);
        repeat (3 * NSTG) @(posedge clk);
        $display("checked %0d tanh results from %0d operands (specials, limits, random)",
                 n_results, total_items);
        if (n_errors == 0 && expected_tanh.size() == 0)
            $display("tb_bf16_tanh_taylor: done, clean");
        else
            $display("tb_bf16_tanh_taylor: done, errors");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb_bf16_tanh_taylor: done, errors");
        $finish;
    end

endmodule

// ----- bf16_tanh_taylor.f -----
design/bft_pkg.sv
design/bft_mul_stage.sv
design/bft_add_stage.sv
design/bft_reduce.sv
design/bf16_tanh_taylor.sv
test/tb_bf16_tanh_taylor.sv
